### rtl/lkf_pkg.sv
`default_nettype none
package lkf_pkg;

  localparam int STATE_DIM = 3;
  localparam int FRAC_BITS = 16;
  localparam int COEF_FRAC = 12;
  localparam int DATA_W    = 32;
  localparam int COEF_W    = 16;
  localparam int REG_W     = 64;
  localparam int NUM_REGS  = 7;
  localparam int REG_IDX_W = 3;

  localparam int MEM_AW    = 6;
  localparam int MEM_DEPTH = 64;
  localparam int ACC_W     = 68;
  localparam int DIV_W     = DATA_W + FRAC_BITS;
  localparam int DIVC_W    = $clog2(DIV_W);

  // Q4.12 -> Q16.16 conversion
  localparam int QUP  = (FRAC_BITS >= COEF_FRAC) ? FRAC_BITS - COEF_FRAC : 0;
  localparam int QDN  = (FRAC_BITS <  COEF_FRAC) ? COEF_FRAC - FRAC_BITS : 0;
  localparam int QRND = (2 ** QDN) / 2;
  localparam int PROD_RND = 2 ** (FRAC_BITS - 1);
  localparam int COEF_RND = 2 ** (COEF_FRAC - 1);
  localparam int COEF_ONE = 2 ** COEF_FRAC;
  localparam int Q_ONE    = 2 ** FRAC_BITS;

  // register indexes
  localparam int REG_TA   = 0;
  localparam int REG_TB   = 1;
  localparam int REG_TC   = 2;
  localparam int REG_OBS  = 3;
  localparam int REG_NA   = 4;
  localparam int REG_NB   = 5;
  localparam int REG_NC   = 6;
  localparam logic [REG_W-1:0] TRANS_RST = REG_W'(4096);

  // work memory map
  localparam int A_X   = 0;
  localparam int A_P   = 3;
  localparam int A_XP  = 12;
  localparam int A_M   = 21;
  localparam int A_PP  = 30;
  localparam int A_PC  = 39;
  localparam int A_KG  = 42;
  localparam int A_IKC = 45;

endpackage
`default_nettype wire

### rtl/linear_kalman_filter_step.sv
`default_nettype none
// Three-state linear Kalman filter, one control input and one measurement, Q16.16 data
// and Q4.12 coefficients. State, covariance and all intermediate matrices live in one
// 64-entry work memory (two read ports, one write port, registered read). A single
// 32x32 multiplier with a four-stage read/multiply/accumulate/round pipeline issues one
// product term per cycle, with a drain state between dependent passes. The gain uses
// a restoring divider at one quotient bit per cycle, run once per state element. When the
// innovation variance is not positive, the divider and update passes are skipped. One item
// is in flight at a time; a finished result waits in the output register while the next
// item is accepted. Configuration writes take effect at once and must be issued only
// while the block is idle.
module linear_kalman_filter_step (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [lkf_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [lkf_pkg::REG_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [lkf_pkg::DATA_W-1:0] ctrl_u,
  input  logic signed [lkf_pkg::DATA_W-1:0] meas_y,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [lkf_pkg::DATA_W-1:0] est_x0,
  output logic signed [lkf_pkg::DATA_W-1:0] est_x1,
  output logic signed [lkf_pkg::DATA_W-1:0] est_x2,
  output logic signed [lkf_pkg::DATA_W-1:0] pred_x0,
  output logic signed [lkf_pkg::DATA_W-1:0] pred_x1,
  output logic signed [lkf_pkg::DATA_W-1:0] pred_x2,
  output logic signed [lkf_pkg::DATA_W-1:0] pred_y,
  output logic innov_singular
);
  import lkf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RUN, S_DRAIN, S_ECALC, S_DRD, S_DLOAD, S_DIV, S_DWR, S_FIN
  } state_t;

  typedef enum logic [3:0] {
    PH_XP, PH_YP, PH_M, PH_PP, PH_PC, PH_S, PH_CPX, PH_CPP, PH_EST, PH_IKC, PH_PN
  } phase_t;

  typedef enum logic [1:0] {OB_COEF, OB_E, OB_MEM1} opb_t;

  typedef struct packed {
    logic                       v;
    logic                       first;
    logic                       last;
    logic                       opa_u;
    opb_t                       opb;
    logic signed [COEF_W-1:0]   coef;
    logic                       perprod;
    logic                       neg;
    logic                       bias_mem;
    logic signed [DATA_W-1:0]   bias;
    logic                       wr_mem;
    logic                       wr_yp;
    logic                       wr_s;
    logic [MEM_AW-1:0]          dest;
  } term_t;

  localparam logic signed [ACC_W-1:0] SMAX = ACC_W'(64'sh7fff_ffff);
  localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);

  function automatic logic signed [COEF_W-1:0] fld(input logic [REG_W-1:0] r,
                                                   input logic [1:0] k);
    return $signed(r[k*COEF_W +: COEF_W]);
  endfunction

  function automatic logic signed [COEF_W-1:0] mat_of(input logic [REG_W-1:0] r0,
                                                      input logic [REG_W-1:0] r1,
                                                      input logic [REG_W-1:0] r2,
                                                      input logic [3:0] n);
    if (n < 4'd4) return fld(r0, n[1:0]);
    else if (n < 4'd8) return fld(r1, n[1:0]);
    else return fld(r2, 2'd0);
  endfunction

  function automatic logic signed [DATA_W-1:0] qconv(input logic signed [COEF_W-1:0] c);
    logic signed [DATA_W-1:0] w;
    w = DATA_W'(c);
    if (FRAC_BITS >= COEF_FRAC) return w <<< QUP;
    else return (w + DATA_W'(QRND)) >>> QDN;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > SMAX) return SMAX[DATA_W-1:0];
    else if (v < SMIN) return SMIN[DATA_W-1:0];
    else return v[DATA_W-1:0];
  endfunction

  function automatic logic [3:0] idx9(input logic [1:0] i, input logic [1:0] k);
    return {1'b0, i, 1'b0} + 4'(i) + 4'(k);
  endfunction

  function automatic logic [MEM_AW-1:0] ad(input int base, input logic [3:0] off);
    return MEM_AW'(base) + MEM_AW'(off);
  endfunction

  logic [REG_W-1:0] cfg [NUM_REGS];
  state_t state;
  phase_t phase;
  logic [1:0] ci, cj, ck, ti, tj, tk, dcnt, di;
  logic signed [DATA_W-1:0] u, y, e, s, yp, kq;
  logic signed [DATA_W-1:0] res_est [STATE_DIM];
  logic signed [DATA_W-1:0] res_pred [STATE_DIM];
  logic sing;
  logic [DIV_W-1:0] dvd;
  logic [DATA_W-1:0] rem, pmag;
  logic [DATA_W:0] trial;
  logic ge, dneg;
  logic [DIVC_W-1:0] bitcnt;

  logic [DATA_W-1:0] mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] valid;
  logic [MEM_AW-1:0] ra0, ra1, wa;
  logic [DATA_W-1:0] rd0, rd1, wd;
  logic vld0, vld1, we;
  logic signed [DATA_W-1:0] m0, m1, opa, opb, res;

  term_t td, d1, d1m, d2, d3;
  logic signed [2*DATA_W-1:0] prod;
  logic signed [ACC_W-1:0] acc, pterm, sh, bias_x, val;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < NUM_REGS; n++) begin
        cfg[n] <= (n <= REG_TC) ? TRANS_RST : '0;
      end
    end else if (cfg_valid && cfg_ready && cfg_index < REG_IDX_W'(NUM_REGS)) begin
      cfg[cfg_index] <= cfg_data;
    end
  end

  // term issue
  always_comb begin
    td = '0;
    ra0 = '0;
    ra1 = '0;
    tk = 2'd0;
    tj = 2'd0;
    ti = 2'd2;
    td.opb = OB_COEF;
    td.first = (ck == 2'd0);
    unique case (phase)
      PH_XP: begin
        tk = 2'd3;
        td.wr_mem = 1'b1;
        td.dest = ad(A_XP, 4'(ci));
        if (ck == 2'd0) begin
          td.opa_u = 1'b1;
          td.coef = fld(cfg[REG_TC], ci + 2'd1);
        end else begin
          ra0 = ad(A_X, 4'(ck - 2'd1));
          td.coef = mat_of(cfg[REG_TA], cfg[REG_TB], cfg[REG_TC], idx9(ci, ck - 2'd1));
        end
      end
      PH_YP: begin
        tk = 2'd3;
        ti = 2'd0;
        td.wr_yp = 1'b1;
        if (ck == 2'd0) begin
          td.opa_u = 1'b1;
          td.coef = fld(cfg[REG_OBS], 2'd3);
        end else begin
          ra0 = ad(A_XP, 4'(ck - 2'd1));
          td.coef = fld(cfg[REG_OBS], ck - 2'd1);
        end
      end
      PH_M: begin
        tk = 2'd2;
        tj = 2'd2;
        ra0 = ad(A_P, idx9(ck, cj));
        td.coef = mat_of(cfg[REG_TA], cfg[REG_TB], cfg[REG_TC], idx9(ci, ck));
        td.wr_mem = 1'b1;
        td.dest = ad(A_M, idx9(ci, cj));
      end
      PH_PP: begin
        tk = 2'd2;
        tj = 2'd2;
        ra0 = ad(A_M, idx9(ci, ck));
        td.coef = mat_of(cfg[REG_TA], cfg[REG_TB], cfg[REG_TC], idx9(cj, ck));
        td.bias = qconv(mat_of(cfg[REG_NA], cfg[REG_NB], cfg[REG_NC], idx9(ci, cj)));
        td.wr_mem = 1'b1;
        td.dest = ad(A_PP, idx9(ci, cj));
      end
      PH_PC: begin
        tk = 2'd2;
        ra0 = ad(A_PP, idx9(ci, ck));
        td.coef = fld(cfg[REG_OBS], ck);
        td.wr_mem = 1'b1;
        td.dest = ad(A_PC, 4'(ci));
      end
      PH_S: begin
        tk = 2'd2;
        ti = 2'd0;
        ra0 = ad(A_PC, 4'(ck));
        td.coef = fld(cfg[REG_OBS], ck);
        td.bias = qconv(fld(cfg[REG_NC], 2'd1));
        td.wr_s = 1'b1;
      end
      PH_CPX: begin
        ra0 = ad(A_XP, 4'(ci));
        td.coef = COEF_W'(COEF_ONE);
        td.wr_mem = 1'b1;
        td.dest = ad(A_X, 4'(ci));
      end
      PH_CPP: begin
        tj = 2'd2;
        ra0 = ad(A_PP, idx9(ci, cj));
        td.coef = COEF_W'(COEF_ONE);
        td.wr_mem = 1'b1;
        td.dest = ad(A_P, idx9(ci, cj));
      end
      PH_EST: begin
        ra0 = ad(A_KG, 4'(ci));
        ra1 = ad(A_XP, 4'(ci));
        td.opb = OB_E;
        td.perprod = 1'b1;
        td.bias_mem = 1'b1;
        td.wr_mem = 1'b1;
        td.dest = ad(A_X, 4'(ci));
      end
      PH_IKC: begin
        tj = 2'd2;
        ra0 = ad(A_KG, 4'(ci));
        td.coef = fld(cfg[REG_OBS], cj);
        td.neg = 1'b1;
        td.bias = (ci == cj) ? DATA_W'(Q_ONE) : '0;
        td.wr_mem = 1'b1;
        td.dest = ad(A_IKC, idx9(ci, cj));
      end
      PH_PN: begin
        tk = 2'd2;
        tj = 2'd2;
        ra0 = ad(A_IKC, idx9(ci, ck));
        ra1 = ad(A_PP, idx9(ck, cj));
        td.opb = OB_MEM1;
        td.perprod = 1'b1;
        td.wr_mem = 1'b1;
        td.dest = ad(A_P, idx9(ci, cj));
      end
      default: ;
    endcase
    td.last = (ck == tk);
    td.v = (state == S_RUN);
    if (state == S_DRD) ra0 = ad(A_PC, 4'(di));
  end

  // work memory
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end

  always_ff @(posedge clk) begin
    if (rst) valid <= '0;
    else if (we) valid[wa] <= 1'b1;
    vld0 <= valid[ra0];
    vld1 <= valid[ra1];
  end

  assign m0 = vld0 ? $signed(rd0) : '0;
  assign m1 = vld1 ? $signed(rd1) : '0;

  // multiply-accumulate pipeline
  always_comb begin
    opa = d1.opa_u ? u : m0;
    case (d1.opb)
      OB_E:    opb = e;
      OB_MEM1: opb = m1;
      default: opb = DATA_W'(d1.coef);
    endcase
    d1m = d1;
    if (d1.bias_mem) d1m.bias = m1;
    pterm = d2.perprod ? ((ACC_W'(prod) + ACC_W'(PROD_RND)) >>> FRAC_BITS)
                       : ACC_W'(prod);
    sh = d3.perprod ? acc : ((acc + ACC_W'(COEF_RND)) >>> COEF_FRAC);
    bias_x = ACC_W'(d3.bias);
    val = d3.neg ? bias_x - sh : sh + bias_x;
    res = sat32(val);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d1 <= '0;
      d2 <= '0;
      d3 <= '0;
    end else begin
      d1 <= td;
      d2 <= d1m;
      d3 <= d2;
    end
    prod <= opa * opb;
    acc <= (d2.first ? '0 : acc) + pterm;
  end

  // divider datapath
  always_comb begin
    pmag = m0[DATA_W-1] ? -m0 : m0;
    trial = {rem, dvd[DIV_W-1]};
    ge = trial >= {1'b0, s};
    if (dneg) kq = (dvd > DIV_W'(64'h8000_0000)) ? 32'sh8000_0000 : -dvd[DATA_W-1:0];
    else kq = (dvd > DIV_W'(64'h7fff_ffff)) ? 32'sh7fff_ffff : dvd[DATA_W-1:0];
  end

  always_comb begin
    if (state == S_DWR) begin
      we = 1'b1;
      wa = ad(A_KG, 4'(di));
      wd = kq;
    end else begin
      we = d3.v && d3.last && d3.wr_mem;
      wa = d3.dest;
      wd = res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FIN && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (d3.v && d3.last) begin
        if (d3.wr_yp) yp <= res;
        if (d3.wr_s) s <= res;
        for (int n = 0; n < STATE_DIM; n++) begin
          if (d3.wr_mem && d3.dest == ad(A_X, 4'(n))) res_est[n] <= res;
          if (d3.wr_mem && d3.dest == ad(A_XP, 4'(n))) res_pred[n] <= res;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            u <= ctrl_u;
            y <= meas_y;
            phase <= PH_XP;
            ci <= '0;
            cj <= '0;
            ck <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (ck == tk) begin
            ck <= '0;
            if (cj == tj) begin
              cj <= '0;
              if (ci == ti) begin
                ci <= '0;
                dcnt <= '0;
                state <= S_DRAIN;
              end else begin
                ci <= ci + 2'd1;
              end
            end else begin
              cj <= cj + 2'd1;
            end
          end else begin
            ck <= ck + 2'd1;
          end
        end
        S_DRAIN: begin
          dcnt <= dcnt + 2'd1;
          if (dcnt == 2'd3) begin
            unique case (phase)
              PH_XP: begin
                phase <= PH_YP;
                state <= S_RUN;
              end
              PH_YP: begin
                phase <= PH_M;
                state <= S_RUN;
              end
              PH_M: begin
                phase <= PH_PP;
                state <= S_RUN;
              end
              PH_PP: begin
                phase <= PH_PC;
                state <= S_RUN;
              end
              PH_PC: begin
                phase <= PH_S;
                state <= S_RUN;
              end
              PH_S: state <= S_ECALC;
              PH_CPX: begin
                phase <= PH_CPP;
                state <= S_RUN;
              end
              PH_EST: begin
                phase <= PH_IKC;
                state <= S_RUN;
              end
              PH_IKC: begin
                phase <= PH_PN;
                state <= S_RUN;
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_ECALC: begin
          sing <= (s <= 0);
          if (s <= 0) begin
            phase <= PH_CPX;
            state <= S_RUN;
          end else begin
            e <= sat32(ACC_W'(y) - ACC_W'(yp));
            di <= '0;
            state <= S_DRD;
          end
        end
        S_DRD: state <= S_DLOAD;
        S_DLOAD: begin
          dneg <= m0[DATA_W-1];
          dvd <= DIV_W'(pmag) << FRAC_BITS;
          rem <= '0;
          bitcnt <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= ge ? DATA_W'(trial - {1'b0, s}) : trial[DATA_W-1:0];
          dvd <= {dvd[DIV_W-2:0], ge};
          bitcnt <= bitcnt + DIVC_W'(1);
          if (bitcnt == DIVC_W'(DIV_W - 1)) state <= S_DWR;
        end
        S_DWR: begin
          if (di == 2'd2) begin
            phase <= PH_EST;
            state <= S_RUN;
          end else begin
            di <= di + 2'd1;
            state <= S_DRD;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            est_x0 <= res_est[0];
            est_x1 <= res_est[1];
            est_x2 <= res_est[2];
            pred_x0 <= res_pred[0];
            pred_x1 <= res_pred[1];
            pred_x2 <= res_pred[2];
            pred_y <= yp;
            innov_singular <= sing;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/lkf_checker.sv
`default_nettype none
module lkf_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [lkf_pkg::DATA_W-1:0] est_x0,
  input logic signed [lkf_pkg::DATA_W-1:0] est_x1,
  input logic signed [lkf_pkg::DATA_W-1:0] est_x2,
  input logic signed [lkf_pkg::DATA_W-1:0] pred_x0,
  input logic signed [lkf_pkg::DATA_W-1:0] pred_x1,
  input logic signed [lkf_pkg::DATA_W-1:0] pred_x2,
  input logic signed [lkf_pkg::DATA_W-1:0] pred_y,
  input logic innov_singular
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(est_x0) && $stable(pred_x0) && $stable(pred_y))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  a_singular: assert property (@(posedge clk) disable iff (rst)
    out_valid && innov_singular |->
      est_x0 == pred_x0 && est_x1 == pred_x1 && est_x2 == pred_x2)
    else $error("skipped update changed the state");

endmodule

bind linear_kalman_filter_step lkf_checker u_lkf_checker (.*);
`default_nettype wire
